[hdl/fhita_pkg.sv]
// shared types and constants for the flow hard and idle timeout aging block
`default_nettype none
package fhita_pkg;
   localparam int FlowsDefault = 64;
   localparam int TimeW = 48;
   localparam int SecW = 16;
   localparam int SlotW = 16;
   localparam logic [9:0] MsPerS = 10'd1000;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_TOUCH = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_TICK = 2'd3;

   localparam logic [2:0] EV_ACCEPTED = 3'd0;
   localparam logic [2:0] EV_REJECTED = 3'd1;
   localparam logic [2:0] EV_HARD = 3'd2;
   localparam logic [2:0] EV_IDLE = 3'd3;
   localparam logic [2:0] EV_TICK_DONE = 3'd4;

   localparam logic REG_SLOT = 1'b0;
   localparam logic REG_MAX = 1'b1;

   typedef struct packed {
      logic start;
      logic [TimeW-1:0] base;
      logic [SecW-1:0] secs;
   } slot_req_type;

   typedef struct packed {
      logic done;
      logic [TimeW-1:0] value;
   } slot_rsp_type;
endpackage
`default_nettype wire

[hdl/fhita_slot_unit.sv]
// deadline unit: base plus seconds, rounded up to the slot length by serial remainder
`default_nettype none
module fhita_slot_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic [fhita_pkg::SlotW-1:0] slot_length,
   input wire fhita_pkg::slot_req_type req,
   output fhita_pkg::slot_rsp_type rsp
);
   import fhita_pkg::*;

   localparam int SumW = TimeW + 1;
   localparam int CntW = $clog2(SumW + 1);

   typedef enum logic [1:0] {U_IDLE, U_DIV, U_FIX} ustate_type;

   ustate_type state_ff, state_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [SlotW:0] rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [TimeW-1:0] val_ff, val_in;

   logic [SlotW:0] shifted;
   logic [SumW-1:0] fixed;

   always_comb begin
      state_in = state_ff;
      sum_in = sum_ff;
      slot_in = slot_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      val_in = val_ff;
      shifted = {rem_ff[SlotW-1:0], sum_ff[cnt_ff[CntW-1:0] - CntW'(1)]};
      fixed = sum_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (req.start) begin
               sum_in = SumW'(req.base) + SumW'(req.secs) * SumW'(MsPerS);
               slot_in = (slot_length == '0) ? SlotW'(1) : slot_length;
               rem_in = '0;
               cnt_in = CntW'(SumW);
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            rem_in = (shifted >= {1'b0, slot_ff}) ? shifted - {1'b0, slot_ff} : shifted;
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) state_in = U_FIX;
         end
         U_FIX: begin
            if (rem_ff != '0) fixed = sum_ff + SumW'(slot_ff) - SumW'(rem_ff);
            val_in = fixed[SumW-1] ? {TimeW{1'b1}} : fixed[TimeW-1:0];
            done_in = 1'b1;
            state_in = U_IDLE;
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      sum_ff <= sum_in;
      slot_ff <= slot_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      val_ff <= val_in;
   end

   assign rsp.done = done_ff;
   assign rsp.value = val_ff;
endmodule
`default_nettype wire

[hdl/flow_hard_idle_timeout_aging.sv]
// flow table hard and idle timeout aging: sequencer, timer memories and csr port
// Usage: the req channel takes one word per operation (add, touch, remove, tick),
// the rsp channel returns event words, both with valid and stall. Configuration
// registers slot_length_ms (0x0) and max_timeout_s (0x4) sit on the csr port.
// Add, touch and remove give one rsp word with last set. An add runs the
// shared deadline unit once per nonzero timeout. A tick scans all FLOWS
// entries in index order and runs the deadline unit when an idle check comes
// due. It gives one word per expired flow, last on the final one, or a
// single tick done word when nothing expires. The serial remainder of the
// deadline unit sets the per-deadline cost.
// req_stall stays high while an operation is in progress. A stalled rsp word
// holds; the scan waits when a second event finds the output still full.
// Reset disarms every flow and restores the csr defaults; timer memories are
// not cleared and their contents are used only for armed flows.
`default_nettype none
module flow_hard_idle_timeout_aging #(
   parameter int FLOWS = fhita_pkg::FlowsDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_op,
   input wire logic [5:0] req_flow_index,
   input wire logic [fhita_pkg::TimeW-1:0] req_now_ms,
   input wire logic [fhita_pkg::SecW-1:0] req_idle_timeout_s,
   input wire logic [fhita_pkg::SecW-1:0] req_hard_timeout_s,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [5:0] rsp_event_flow,
   output logic [2:0] rsp_event_kind,
   output logic rsp_last,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [2:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import fhita_pkg::*;

   localparam int IW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ADD_IDLE, ST_ADD_HARD, ST_DONE,
      ST_RD, ST_EVAL, ST_IDLE_WAIT, ST_PUSH, ST_NEXT, ST_FIN
   } state_type;

   state_type state_ff;
   logic [SlotW-1:0] slot_ff;
   logic [SecW-1:0] max_ff;

   logic [5:0] fi_ff;
   logic [TimeW-1:0] now_ff;
   logic [SecW-1:0] hard_ff;
   logic [2:0] kind_ff;

   logic [FLOWS-1:0] armed_hard_ff, armed_idle_ff;
   logic [TimeW-1:0] hard_mem [FLOWS];
   logic [TimeW-1:0] check_mem [FLOWS];
   logic [TimeW-1:0] use_mem [FLOWS];
   logic [SecW-1:0] period_mem [FLOWS];
   logic [TimeW-1:0] hard_q_ff, check_q_ff, use_q_ff;
   logic [SecW-1:0] period_q_ff;

   logic [IW-1:0] idx_ff;
   logic hd_ff;
   logic [2:0] exp_kind_ff;
   logic pend_ff;
   logic [IW-1:0] pend_flow_ff;
   logic [2:0] pend_kind_ff;

   logic rsp_valid_ff;
   logic [5:0] rsp_flow_ff;
   logic [2:0] rsp_kind_ff;
   logic rsp_last_ff;

   slot_req_type ureq_ff;
   slot_rsp_type ursp;

   logic out_free, csr_write, accept, in_range, reject, hd, id;
   logic [IW-1:0] req_addr;

   fhita_slot_unit u_slot (
      .clock(clock),
      .reset(reset),
      .slot_length(slot_ff),
      .req(ureq_ff),
      .rsp(ursp)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX) ? {16'd0, max_ff} : {16'd0, slot_ff};
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && (state_ff == ST_IDLE);
   assign in_range = ({1'b0, req_flow_index} < 7'(FLOWS));
   assign req_addr = req_flow_index[IW-1:0];
   assign reject = ((req_idle_timeout_s != '0) && (req_idle_timeout_s > max_ff))
                || ((req_hard_timeout_s != '0) && (req_hard_timeout_s > max_ff));
   assign hd = armed_hard_ff[idx_ff] && (hard_q_ff <= now_ff);
   assign id = armed_idle_ff[idx_ff] && (check_q_ff <= now_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_flow = rsp_flow_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_last = rsp_last_ff;

   always_ff @(posedge clock) begin
      hard_q_ff <= hard_mem[idx_ff];
      check_q_ff <= check_mem[idx_ff];
      use_q_ff <= use_mem[idx_ff];
      period_q_ff <= period_mem[idx_ff];
      if (accept && req_op == OP_ADD && in_range && !reject) begin
         use_mem[req_addr] <= req_now_ms;
      end else if (accept && req_op == OP_TOUCH && in_range && armed_idle_ff[req_addr]) begin
         use_mem[req_addr] <= req_now_ms;
      end
      if (accept && req_op == OP_ADD && in_range && !reject && req_idle_timeout_s != '0) begin
         period_mem[req_addr] <= req_idle_timeout_s;
      end
      if (state_ff == ST_ADD_IDLE && ursp.done) begin
         check_mem[fi_ff[IW-1:0]] <= ursp.value;
      end else if (state_ff == ST_IDLE_WAIT && ursp.done && ursp.value > now_ff) begin
         check_mem[idx_ff] <= ursp.value;
      end
      if (state_ff == ST_ADD_HARD && ursp.done) begin
         hard_mem[fi_ff[IW-1:0]] <= ursp.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff <= 16'd1000;
         max_ff <= 16'd255;
         armed_hard_ff <= '0;
         armed_idle_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         ureq_ff.start <= 1'b0;
         idx_ff <= '0;
      end else begin
         ureq_ff.start <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            if (csr_paddr[2] == REG_SLOT) slot_ff <= csr_pwdata[15:0];
            else max_ff <= csr_pwdata[15:0];
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  fi_ff <= req_flow_index;
                  now_ff <= req_now_ms;
                  hard_ff <= req_hard_timeout_s;
                  kind_ff <= EV_ACCEPTED;
                  state_ff <= ST_DONE;
                  if (req_op == OP_TICK) begin
                     idx_ff <= '0;
                     pend_ff <= 1'b0;
                     state_ff <= ST_RD;
                  end else if (in_range) begin
                     if (req_op == OP_ADD) begin
                        if (reject) begin
                           kind_ff <= EV_REJECTED;
                        end else begin
                           armed_idle_ff[req_addr] <= (req_idle_timeout_s != '0);
                           armed_hard_ff[req_addr] <= (req_hard_timeout_s != '0);
                           ureq_ff.base <= req_now_ms;
                           if (req_idle_timeout_s != '0) begin
                              ureq_ff.start <= 1'b1;
                              ureq_ff.secs <= req_idle_timeout_s;
                              state_ff <= ST_ADD_IDLE;
                           end else if (req_hard_timeout_s != '0) begin
                              ureq_ff.start <= 1'b1;
                              ureq_ff.secs <= req_hard_timeout_s;
                              state_ff <= ST_ADD_HARD;
                           end
                        end
                     end else if (req_op == OP_REMOVE) begin
                        armed_idle_ff[req_addr] <= 1'b0;
                        armed_hard_ff[req_addr] <= 1'b0;
                     end
                  end
               end
            end
            ST_ADD_IDLE: begin
               if (ursp.done) begin
                  if (hard_ff != '0) begin
                     ureq_ff.start <= 1'b1;
                     ureq_ff.secs <= hard_ff;
                     state_ff <= ST_ADD_HARD;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_ADD_HARD: begin
               if (ursp.done) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_flow_ff <= fi_ff;
                  rsp_kind_ff <= kind_ff;
                  rsp_last_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_RD: state_ff <= ST_EVAL;
            ST_EVAL: begin
               hd_ff <= hd;
               if (id && (!hd || check_q_ff <= hard_q_ff)) begin
                  ureq_ff.start <= 1'b1;
                  ureq_ff.base <= use_q_ff;
                  ureq_ff.secs <= period_q_ff;
                  state_ff <= ST_IDLE_WAIT;
               end else if (hd) begin
                  armed_idle_ff[idx_ff] <= 1'b0;
                  armed_hard_ff[idx_ff] <= 1'b0;
                  exp_kind_ff <= EV_HARD;
                  state_ff <= ST_PUSH;
               end else begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_IDLE_WAIT: begin
               if (ursp.done) begin
                  if (ursp.value <= now_ff || hd_ff) begin
                     armed_idle_ff[idx_ff] <= 1'b0;
                     armed_hard_ff[idx_ff] <= 1'b0;
                     exp_kind_ff <= (ursp.value <= now_ff) ? EV_IDLE : EV_HARD;
                     state_ff <= ST_PUSH;
                  end else begin
                     state_ff <= ST_NEXT;
                  end
               end
            end
            ST_PUSH: begin
               if (!pend_ff || out_free) begin
                  if (pend_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_flow_ff <= 6'(pend_flow_ff);
                     rsp_kind_ff <= pend_kind_ff;
                     rsp_last_ff <= 1'b0;
                  end
                  pend_ff <= 1'b1;
                  pend_flow_ff <= idx_ff;
                  pend_kind_ff <= exp_kind_ff;
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (idx_ff == IW'(FLOWS - 1)) begin
                  state_ff <= ST_FIN;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
                  state_ff <= ST_RD;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_flow_ff <= pend_ff ? 6'(pend_flow_ff) : 6'd0;
                  rsp_kind_ff <= pend_ff ? pend_kind_ff : EV_TICK_DONE;
                  rsp_last_ff <= 1'b1;
                  pend_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[tb/tb.sv]
// testbench for the flow hard and idle timeout aging block: predictor, scoreboard and stimulus
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fhita_pkg::*;

   localparam int WatchLimit = 40000;
   localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [5:0] flow;
      logic [2:0] kind;
      logic last;
   } event_word_type;

   class aging_scoreboard;
      logic armed_hard[64];
      logic armed_idle[64];
      logic [47:0] hard_dl[64];
      logic [47:0] idle_chk[64];
      logic [47:0] last_use[64];
      logic [15:0] idle_per[64];
      logic [15:0] slot_len;
      logic [15:0] max_to;
      event_word_type pending[$];
      int errors;

      function new();
         slot_len = 16'd1000;
         max_to = 16'd255;
         errors = 0;
         for (int i = 0; i < 64; i++) begin
            armed_hard[i] = 1'b0;
            armed_idle[i] = 1'b0;
         end
      endfunction

      function logic [47:0] round_deadline(logic [47:0] base, logic [15:0] secs);
         logic [63:0] sl;
         logic [63:0] t;
         logic [63:0] r;
         sl = (slot_len == 0) ? 64'd1 : {48'd0, slot_len};
         t = {16'd0, base} + {48'd0, secs} * 64'd1000;
         r = t % sl;
         if (r != 0) t = t + sl - r;
         if (t > {16'd0, TimeMax}) t = {16'd0, TimeMax};
         return t[47:0];
      endfunction

      function void push(logic [5:0] f, logic [2:0] k, logic l);
         event_word_type w;
         w.flow = f;
         w.kind = k;
         w.last = l;
         pending.push_back(w);
      endfunction

      function void note(logic [1:0] op, logic [5:0] fi, logic [47:0] now,
                         logic [15:0] idle, logic [15:0] hard);
         int n;
         logic hd;
         logic id;
         logic [47:0] e;
         n = 0;
         if (op == OP_TICK) begin
            for (int i = 0; i < 64; i++) begin
               hd = armed_hard[i] && hard_dl[i] <= now;
               id = armed_idle[i] && idle_chk[i] <= now;
               if (id && (!hd || idle_chk[i] <= hard_dl[i])) begin
                  e = round_deadline(last_use[i], idle_per[i]);
                  if (e <= now) begin
                     armed_hard[i] = 1'b0;
                     armed_idle[i] = 1'b0;
                     push(i[5:0], EV_IDLE, 1'b0);
                     n++;
                     continue;
                  end
                  idle_chk[i] = e;
               end
               if (hd) begin
                  armed_hard[i] = 1'b0;
                  armed_idle[i] = 1'b0;
                  push(i[5:0], EV_HARD, 1'b0);
                  n++;
               end
            end
            if (n == 0) push(6'd0, EV_TICK_DONE, 1'b1);
            else pending[pending.size()-1].last = 1'b1;
         end else if (op == OP_ADD) begin
            if ((idle != 0 && idle > max_to) || (hard != 0 && hard > max_to)) begin
               push(fi, EV_REJECTED, 1'b1);
            end else begin
               armed_idle[fi] = idle != 0;
               armed_hard[fi] = hard != 0;
               last_use[fi] = now;
               if (idle != 0) begin
                  idle_per[fi] = idle;
                  idle_chk[fi] = round_deadline(now, idle);
               end
               if (hard != 0) hard_dl[fi] = round_deadline(now, hard);
               push(fi, EV_ACCEPTED, 1'b1);
            end
         end else begin
            if (op == OP_TOUCH) begin
               if (armed_idle[fi]) last_use[fi] = now;
            end else begin
               armed_hard[fi] = 1'b0;
               armed_idle[fi] = 1'b0;
            end
            push(fi, EV_ACCEPTED, 1'b1);
         end
      endfunction

      function void check(logic [5:0] f, logic [2:0] k, logic l);
         event_word_type w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word flow %0d kind %0d last %0d", $time, f, k, l);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (w.flow !== f) begin
            $display("%0t: event_flow expected %0d actual %0d", $time, w.flow, f);
            errors++;
         end
         if (w.kind !== k) begin
            $display("%0t: event_kind expected %0d actual %0d", $time, w.kind, k);
            errors++;
         end
         if (w.last !== l) begin
            $display("%0t: last expected %0d actual %0d", $time, w.last, l);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_op = OP_TICK;
   logic [5:0] req_flow_index = '0;
   logic [47:0] req_now_ms = '0;
   logic [15:0] req_idle_timeout_s = '0;
   logic [15:0] req_hard_timeout_s = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [5:0] rsp_event_flow;
   logic [2:0] rsp_event_kind;
   logic rsp_last;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   flow_hard_idle_timeout_aging uut (.*);

   always #5 clock = ~clock;

   aging_scoreboard sb = new();
   int send_pct = 0;
   int stall_pct = 0;
   bit hold_req = 0;
   int hold_cnt = 0;
   int quiet_cycles = 0;
   logic [47:0] clock_ms = '0;

   always @(posedge clock) begin
      if (hold_req && hold_cnt == 0) begin
         hold_cnt = 1500;
         hold_req = 0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check(rsp_event_flow, rsp_event_kind, rsp_last);
   end

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] op, logic [5:0] fi, logic [47:0] now,
                            logic [15:0] idle, logic [15:0] hard);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_flow_index <= fi;
      req_now_ms <= now;
      req_idle_timeout_s <= idle;
      req_hard_timeout_s <= hard;
      do @(posedge clock); while (req_stall);
      sb.note(op, fi, now, idle, hard);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_timing(logic [15:0] slot, logic [15:0] maxs);
      csr_write({REG_SLOT, 2'b00}, slot);
      csr_write({REG_MAX, 2'b00}, maxs);
      sb.slot_len = slot;
      sb.max_to = maxs;
   endtask

   task automatic random_word();
      logic [1:0] op;
      logic [15:0] lim;
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) begin
         send_word(2'($urandom_range(3)), 6'($urandom_range(63)),
                   48'({$urandom, $urandom}),
                   16'($urandom_range(65535)), 16'($urandom_range(65535)));
         return;
      end
      clock_ms = clock_ms + 48'((($urandom_range(9) == 0) ? $urandom_range(70000)
                                                          : $urandom_range(3000)));
      lim = (sb.max_to > 12) ? 16'd12 : sb.max_to + 16'd1;
      op = (sel < 45) ? OP_ADD : (sel < 65) ? OP_TOUCH : (sel < 75) ? OP_REMOVE : OP_TICK;
      send_word(op, 6'($urandom_range(15)), clock_ms,
                ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(lim)),
                ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(lim)));
   endtask

   initial begin
      int modes_s[5] = '{0, 55, 0, 32, 0};
      int modes_r[5] = '{0, 0, 55, 32, 0};
      logic [15:0] slots[5] = '{16'd1000, 16'd1, 16'd0, 16'd65535, 16'd7};
      logic [15:0] maxes[5] = '{16'd255, 16'd65535, 16'd0, 16'd10, 16'd3};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(OP_ADD, 6'd0, 48'd0, 16'd0, 16'd0);
      send_word(OP_ADD, 6'd63, 48'd0, 16'd255, 16'd255);
      send_word(OP_ADD, 6'd1, 48'd0, 16'd256, 16'd1);
      send_word(OP_ADD, 6'd1, 48'd0, 16'd1, 16'd256);
      send_word(OP_ADD, 6'd2, 48'd500, 16'd0, 16'd1);
      send_word(OP_TOUCH, 6'd2, 48'd600, 16'hFFFF, 16'hFFFF);
      send_word(OP_ADD, 6'd3, 48'd0, 16'd1, 16'd1);
      send_word(OP_TOUCH, 6'd3, 48'd500, 16'd0, 16'd0);
      send_word(OP_ADD, 6'd4, 48'd0, 16'd2, 16'd0);
      send_word(OP_ADD, 6'd5, 48'd0, 16'd1, 16'd5);
      send_word(OP_TOUCH, 6'd5, 48'd1900, 16'd0, 16'd0);
      send_word(OP_TICK, 6'd0, 48'd999, 16'd0, 16'd0);
      send_word(OP_TICK, 6'd0, 48'd2000, 16'd0, 16'd0);
      send_word(OP_ADD, 6'd6, 48'd0, 16'd3, 16'd3);
      send_word(OP_ADD, 6'd6, 48'd100, 16'd0, 16'd1);
      send_word(OP_REMOVE, 6'd63, 48'd0, 16'd0, 16'd0);
      send_word(OP_TICK, 6'd0, 48'd10000, 16'd0, 16'd0);
      drain();

      set_timing(16'd1, 16'd65535);
      send_word(OP_ADD, 6'd10, TimeMax, 16'd65535, 16'd65535);
      send_word(OP_ADD, 6'd11, TimeMax - 48'd5000, 16'd3, 16'd0);
      send_word(OP_TICK, 6'd0, TimeMax, 16'd0, 16'd0);
      send_word(OP_TICK, 6'd0, 48'h5555_5555_5555, 16'd0, 16'd0);
      drain();

      for (int p = 0; p < 5; p++) begin
         set_timing(slots[p], maxes[p]);
         send_pct = modes_s[p];
         stall_pct = modes_r[p];
         if (p == 4) hold_req = 1;
         for (int i = 0; i < 30; i++) random_word();
         send_word(OP_TICK, 6'd0, clock_ms + 48'd200000, 16'd0, 16'd0);
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
hdl/fhita_pkg.sv
hdl/fhita_slot_unit.sv
hdl/flow_hard_idle_timeout_aging.sv
tb/tb.sv
